@@ rtl/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with reset-qualified sampling.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked property that holds even while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/rhc_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the converter.
package rhc_pkg;

    localparam int COMP_W          = 8;    // width of one color sample
    localparam int SECT_W          = 11;   // sector offset, up to 6 * 255
    localparam int NUM_W           = 25;   // widest division numerator
    localparam int REM_W           = 9;    // divisor and remainder width
    localparam int QUOT_W          = 16;   // quotient bits produced
    localparam int HUE_W           = 15;
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = QUOT_W / DIV_STAGES;

    // Hue numerator is 2 * 3840 * sectors + chroma, saturation numerator
    // is 2 * 65535 * chroma + value; both divide by twice the divisor.
    localparam int HUE_NUM_SCALE = 7680;
    localparam int SAT_NUM_SCALE = 131070;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  den;
        logic [QUOT_W-1:0] bits;
    } t_div_lane;

    typedef struct packed {
        t_div_lane         hue;
        t_div_lane         sat;
        logic [COMP_W-1:0] value;
    } t_div_item;

endpackage

@@ rtl/rhc_front.sv @@
// Front end of the converter: max/min/chroma, hue sector offset and
// division operands, in three register stages. Depends on rhc_pkg.
module rhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_take,
    output logic                o_take,
    output logic                o_valid,
    output rhc_pkg::t_div_item  o_data
);
    import rhc_pkg::*;

    // Stage 1: captured samples.
    logic              r1_valid;
    logic [COMP_W-1:0] r1_red, r1_green, r1_blue;
    // Stage 2: value, chroma and sector offset.
    logic              r2_valid;
    logic [COMP_W-1:0] r2_max, r2_chroma;
    logic [SECT_W-1:0] r2_sect;
    // Stage 3: division operands.
    logic              r3_valid;
    t_div_item         r3_data;

    logic en1, en2, en3;
    logic [COMP_W-1:0] n_max, n_min, n_chroma;
    logic [SECT_W-1:0] n_sect;
    logic [NUM_W-1:0]  hue_num, sat_num;
    t_div_item         n_item;

    assign en3    = !r3_valid || i_take;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;
    assign o_take = en1;

    always_comb begin
        n_max = r1_red;
        n_min = r1_red;
        if (r1_green > n_max) n_max = r1_green;
        if (r1_blue  > n_max) n_max = r1_blue;
        if (r1_green < n_min) n_min = r1_green;
        if (r1_blue  < n_min) n_min = r1_blue;
        n_chroma = n_max - n_min;
        // Red wins ties for the maximum, then green, then blue.
        if (n_max == r1_red) begin
            if (r1_green >= r1_blue) begin
                n_sect = SECT_W'(r1_green) - SECT_W'(r1_blue);
            end else begin
                n_sect = SECT_W'(6) * SECT_W'(n_chroma) - SECT_W'(r1_blue)
                       + SECT_W'(r1_green);
            end
        end else if (n_max == r1_green) begin
            n_sect = SECT_W'(2) * SECT_W'(n_chroma) + SECT_W'(r1_blue) - SECT_W'(r1_red);
        end else begin
            n_sect = SECT_W'(4) * SECT_W'(n_chroma) + SECT_W'(r1_red) - SECT_W'(r1_green);
        end
    end

    always_comb begin
        hue_num = NUM_W'(r2_sect) * NUM_W'(HUE_NUM_SCALE) + NUM_W'(r2_chroma);
        sat_num = NUM_W'(r2_chroma) * NUM_W'(SAT_NUM_SCALE) + NUM_W'(r2_max);
        // The quotient fits in QUOT_W bits, so the top numerator bits are
        // already below the divisor and seed the remainder directly.
        n_item.hue.rem  = hue_num[NUM_W-1:QUOT_W];
        n_item.hue.bits = hue_num[QUOT_W-1:0];
        n_item.hue.den  = (r2_chroma == '0) ? REM_W'(1) : {r2_chroma, 1'b0};
        n_item.sat.rem  = sat_num[NUM_W-1:QUOT_W];
        n_item.sat.bits = sat_num[QUOT_W-1:0];
        n_item.sat.den  = (r2_max == '0) ? REM_W'(1) : {r2_max, 1'b0};
        n_item.value    = r2_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_red   <= i_red;
            r1_green <= i_green;
            r1_blue  <= i_blue;
        end
        if (en2) begin
            r2_max    <= n_max;
            r2_chroma <= n_chroma;
            r2_sect   <= n_sect;
        end
        if (en3) begin
            r3_data <= n_item;
        end
    end

    assign o_valid = r3_valid;
    assign o_data  = r3_data;

endmodule

@@ rtl/rhc_div_stage.sv @@
// One stage of the pipelined restoring divider: a few quotient bits for
// both the hue and the saturation lane. Depends on rhc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rhc_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhc_pkg::t_div_item  i_data,
    input  logic                i_take,
    output logic                o_take,
    output logic                o_valid,
    output rhc_pkg::t_div_item  o_data
);
    import rhc_pkg::*;

    logic      r_valid;
    t_div_item r_data;
    t_div_item n_data;
    logic      en;

    function automatic t_div_lane div_steps(input t_div_lane l_in);
        t_div_lane      l;
        logic [REM_W:0] t;
        l = l_in;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            t      = {l.rem, l.bits[QUOT_W-1]};
            l.bits = {l.bits[QUOT_W-2:0], 1'b0};
            if (t >= {1'b0, l.den}) begin
                l.rem     = REM_W'(t - {1'b0, l.den});
                l.bits[0] = 1'b1;
            end else begin
                l.rem = t[REM_W-1:0];
            end
        end
        return l;
    endfunction

    assign en     = !r_valid || i_take;
    assign o_take = en;

    always_comb begin
        n_data       = i_data;
        n_data.hue   = div_steps(i_data.hue);
        n_data.sat   = div_steps(i_data.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `ASSERT_RST(a_hue_rem_below_den, i_clk, i_rst_n, r_valid |-> r_data.hue.rem < r_data.hue.den)
    `ASSERT_RST(a_sat_rem_below_den, i_clk, i_rst_n, r_valid |-> r_data.sat.rem < r_data.sat.den)
    `ASSERT_RST(a_held_when_blocked, i_clk, i_rst_n, r_valid && !i_take |=> r_valid && $stable(r_data))

endmodule

@@ rtl/rgb_to_hsv_converter_unit.sv @@
// Top level of the RGB to HSV converter: front end plus pipelined divider.
// Depends on rhc_pkg, rhc_front, rhc_div_stage and assert_macros.svh.
`include "assert_macros.svh"
// The unit turns one 8-bit RGB pixel into hue (1/64 degree units), saturation
// (65535 means fully saturated) and value (the largest sample), with both
// divisions rounded to nearest and exact halves rounded up. It accepts one pixel
// per clock and delivers one result per clock when the output is not stalled.
// Each pixel passes through three front-end stages (sample capture, max/min and
// sector, division operands) and four divider stages, each producing four of the
// sixteen quotient bits of both divisions. Every stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall on the
// output only stops the pipeline once the bubbles ahead of it have filled. Grey
// pixels give hue zero and black pixels give saturation zero.
module rgb_to_hsv_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_hue,
    output logic [15:0] o_saturation,
    output logic [7:0]  o_value
);
    import rhc_pkg::*;

    // Position 0 is the front-end output; position DIV_STAGES is the last
    // divider stage, whose registers drive the output ports directly.
    t_div_item pipe_data  [DIV_STAGES+1];
    logic      pipe_valid [DIV_STAGES+1];
    logic      pipe_take  [DIV_STAGES+1];
    logic      front_take;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_take  (pipe_take[0]),
        .o_take  (front_take),
        .o_valid (pipe_valid[0]),
        .o_data  (pipe_data[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rhc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (pipe_valid[s]),
            .i_data  (pipe_data[s]),
            .i_take  (pipe_take[s+1]),
            .o_take  (pipe_take[s]),
            .o_valid (pipe_valid[s+1]),
            .o_data  (pipe_data[s+1])
        );
    end

    // The last stage can take new data whenever the consumer is not stalling.
    assign pipe_take[DIV_STAGES] = !i_stall;

    assign o_stall      = !front_take;
    assign o_valid      = pipe_valid[DIV_STAGES];
    assign o_hue        = pipe_data[DIV_STAGES].hue.bits[HUE_W-1:0];
    assign o_saturation = pipe_data[DIV_STAGES].sat.bits;
    assign o_value      = pipe_data[DIV_STAGES].value;

    `ASSERT_RST(a_black_unsaturated, i_clk, i_rst_n, o_valid && o_value == '0 |-> o_saturation == '0)
    `ASSERT_RST(a_hue_in_range, i_clk, i_rst_n, o_valid |-> o_hue < 15'd23040)
    `ASSERT_RST(a_empty_never_stalls, i_clk, i_rst_n, !o_valid |-> !o_stall)

endmodule
